### design/sdcst_pkg.sv
package sdcst_pkg;

    // field and register widths
    localparam int SEC_W      = 14;
    localparam int PCT_W      = 7;
    localparam int IN_TIME_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    // longest phase value: 100 * 1000 * on_time_seconds fits 31 bits
    localparam int PHASE_W = 31;

    // history taps for the serial constant multipliers
    localparam int TAP_W = 17;
    localparam int CY_W  = 3;

    localparam logic [TAP_W-1:0] MS_PER_SEC      = 17'd1000;
    localparam logic [TAP_W-1:0] MS_PER_SEC_X100 = 17'd100000;
    localparam logic [PCT_W-1:0] FULL_PERCENT    = 7'd100;
    localparam logic [PCT_W-1:0] ZERO_PERCENT    = 7'd0;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_SEC   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERCENT  = 2'd2;

    // input func codes
    localparam logic FUNC_CHECK = 1'b0;
    localparam logic FUNC_START = 1'b1;

    typedef struct packed {
        logic calc;   // recompute on-phase and quotient
        logic shift;  // rotate both results by one bit
    } t_ph_req;

    typedef struct packed {
        logic done;
        logic on_bit;
        logic quot_bit;
    } t_ph_rsp;

endpackage

### design/slow_duty_cycle_switch_timer.sv
// channel  | handshake                  | word
// ---------+----------------------------+----------------------------------
// in       | i_in_valid / o_in_stall    | i_func, i_current_time_ms
// out      | o_out_valid / i_out_stall  | o_fan_on, o_drive_level
// cfg      | i_cfg_wr_en                | i_cfg_index, i_cfg_data
//
// one word at a time; start words and words that need no compare go straight to the result
// a check word also passes through the bit-serial compare, max(TIME_WIDTH, 31) bits wide
// after any config write the first such word first runs the serial constant multiply,
// then the serial divide by the percentage, then the handoff to the compare
// reset is synchronous, active low; the result register holds while i_out_stall
// is high, and the next word is taken once the result has been loaded
module slow_duty_cycle_switch_timer #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_func,
    input  logic [sdcst_pkg::IN_TIME_W-1:0]  i_current_time_ms,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_fan_on,
    output logic                             o_drive_level,
    input  logic                             i_cfg_wr_en,
    input  logic [sdcst_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sdcst_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sdcst_pkg::*;

    localparam int CMP_W = (TIME_WIDTH > PHASE_W) ? TIME_WIDTH : PHASE_W;
    localparam int CNT_W = $clog2(CMP_W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_CMP,
        S_DONE
    } t_state;

    t_state                r_state;
    logic                  r_enable;
    logic [SEC_W-1:0]      r_on_sec;
    logic [PCT_W-1:0]      r_percent;
    logic                  r_phase_ok;
    logic                  r_calc_go;
    logic                  r_load_on;
    logic [TIME_WIDTH-1:0] r_last;
    logic [TIME_WIDTH-1:0] r_now;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_be;
    logic                  r_bo;
    logic                  r_bc;
    logic                  r_out_valid;
    logic                  r_out_fan;

    t_ph_req               ph_req;
    t_ph_rsp               ph_rsp;

    logic                  accept;
    logic                  out_free;
    logic                  hold_state;
    logic [TIME_WIDTH-1:0] now_in;
    logic                  tin;
    logic                  pin;
    logic [TIME_WIDTH-1:0] n_now;
    logic [TIME_WIDTH-1:0] n_last;
    logic                  e_b;
    logic                  n_be;
    logic                  on_b;
    logic                  q_b;
    logic                  off_b;
    logic                  n_bo;
    logic                  ph_b;
    logic                  n_bc;
    logic [PCT_W-1:0]      pct_sat;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign now_in     = TIME_WIDTH'(i_current_time_ms);

    // no switch possible: full duty while on, zero duty while off
    assign hold_state = (r_load_on && (r_percent == FULL_PERCENT)) ||
                        (!r_load_on && (r_percent == ZERO_PERCENT));

    assign pct_sat = (i_cfg_data[PCT_W-1:0] > FULL_PERCENT) ? FULL_PERCENT
                                                             : i_cfg_data[PCT_W-1:0];

    assign ph_req.calc  = r_calc_go;
    assign ph_req.shift = (r_state == S_CMP) && pin;

    sdcst_phase u_phase (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (ph_req),
        .i_on_sec  (r_on_sec),
        .i_percent (r_percent),
        .o_rsp     (ph_rsp)
    );

    // bit-serial compare, lsb first: elapsed = now - last, off = quot - on,
    // then elapsed - phase; the final borrow says elapsed < phase
    assign tin    = (32'(r_cnt) < TIME_WIDTH);
    assign pin    = (32'(r_cnt) < PHASE_W);
    assign n_now  = tin ? {r_now[0], r_now[TIME_WIDTH-1:1]} : r_now;
    assign n_last = tin ? {r_last[0], r_last[TIME_WIDTH-1:1]} : r_last;

    assign e_b  = tin & (r_now[0] ^ r_last[0] ^ r_be);
    assign n_be = (~r_now[0] & r_last[0]) | (~(r_now[0] ^ r_last[0]) & r_be);

    assign on_b  = pin & ph_rsp.on_bit;
    assign q_b   = pin & ph_rsp.quot_bit;
    assign off_b = q_b ^ on_b ^ r_bo;
    assign n_bo  = (~q_b & on_b) | (~(q_b ^ on_b) & r_bo);

    assign ph_b = r_load_on ? on_b : off_b;
    assign n_bc = (~e_b & ph_b) | (~(e_b ^ ph_b) & r_bc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_enable    <= 1'b0;
            r_on_sec    <= '0;
            r_percent   <= '0;
            r_phase_ok  <= 1'b0;
            r_calc_go   <= 1'b0;
            r_load_on   <= 1'b0;
            r_last      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_calc_go <= 1'b0;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_now <= now_in;
                        r_cnt <= '0;
                        r_be  <= 1'b0;
                        r_bo  <= 1'b0;
                        r_bc  <= 1'b0;
                        if (i_func == FUNC_START) begin
                            r_load_on <= r_enable;
                            if (r_enable) begin
                                r_last <= now_in;
                            end
                            r_state <= S_DONE;
                        end else if (!r_enable) begin
                            r_load_on <= 1'b0;
                            r_state   <= S_DONE;
                        end else if (hold_state) begin
                            r_state <= S_DONE;
                        end else if (r_phase_ok) begin
                            r_state <= S_CMP;
                        end else begin
                            r_calc_go <= 1'b1;
                            r_state   <= S_CALC;
                        end
                    end
                end
                S_CALC: begin
                    if (ph_rsp.done) begin
                        r_phase_ok <= 1'b1;
                        r_state    <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_now  <= n_now;
                    r_last <= n_last;
                    r_be   <= n_be;
                    r_bo   <= n_bo;
                    r_bc   <= n_bc;
                    if (r_cnt == CNT_W'(CMP_W - 1)) begin
                        if (!n_bc) begin
                            // phase elapsed: toggle and stamp
                            r_load_on <= !r_load_on;
                            r_last    <= n_now;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_fan   <= r_load_on;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (i_cfg_wr_en) begin
                r_phase_ok <= 1'b0;
                case (i_cfg_index)
                    CFG_ENABLE:  r_enable  <= i_cfg_data[0];
                    CFG_ON_SEC:  r_on_sec  <= i_cfg_data[SEC_W-1:0];
                    CFG_PERCENT: r_percent <= pct_sat;
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_fan_on      = r_out_fan;
    assign o_drive_level = ~r_out_fan;

endmodule

### design/sdcst_phase.sv
module sdcst_phase (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sdcst_pkg::t_ph_req          i_req,
    input  logic [sdcst_pkg::SEC_W-1:0] i_on_sec,
    input  logic [sdcst_pkg::PCT_W-1:0] i_percent,
    output sdcst_pkg::t_ph_rsp          o_rsp
);
    import sdcst_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_MUL,
        PH_DIV
    } t_ph_state;

    t_ph_state          r_state;
    logic [4:0]         r_cnt;
    logic               r_done;
    logic [SEC_W-1:0]   r_sec_sh;
    logic [TAP_W-2:0]   r_hist;
    logic [CY_W-1:0]    r_cy_on;
    logic [CY_W-1:0]    r_cy_num;
    logic [PCT_W-1:0]   r_rem;
    logic [PHASE_W-1:0] r_on;
    logic [PHASE_W-1:0] r_num;   // product, then quotient in place

    logic [TAP_W-1:0]  taps;
    logic [CY_W:0]     sum_on;
    logic [CY_W:0]     sum_num;
    logic [PCT_W:0]    trial;
    logic [PCT_W:0]    diff;
    logic              q_bit;
    logic [PCT_W-1:0]  n_rem;

    // taps[j] is sec bit (k - j) at product bit k
    assign taps    = {r_hist, r_sec_sh[0]};
    assign sum_on  = (CY_W+1)'($countones(taps & MS_PER_SEC)) + {1'b0, r_cy_on};
    assign sum_num = (CY_W+1)'($countones(taps & MS_PER_SEC_X100)) + {1'b0, r_cy_num};

    // restoring division, one quotient bit per cycle, msb first
    assign trial = {r_rem, r_num[PHASE_W-1]};
    assign diff  = trial - {1'b0, i_percent};
    assign q_bit = (trial >= {1'b0, i_percent});
    assign n_rem = q_bit ? diff[PCT_W-1:0] : trial[PCT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PH_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                PH_IDLE: begin
                    if (i_req.calc) begin
                        r_sec_sh <= i_on_sec;
                        r_hist   <= '0;
                        r_cy_on  <= '0;
                        r_cy_num <= '0;
                        r_cnt    <= '0;
                        r_state  <= PH_MUL;
                    end else if (i_req.shift) begin
                        r_on  <= {r_on[0], r_on[PHASE_W-1:1]};
                        r_num <= {r_num[0], r_num[PHASE_W-1:1]};
                    end
                end
                PH_MUL: begin
                    r_sec_sh <= {1'b0, r_sec_sh[SEC_W-1:1]};
                    r_hist   <= {r_hist[TAP_W-3:0], r_sec_sh[0]};
                    r_cy_on  <= sum_on[CY_W:1];
                    r_cy_num <= sum_num[CY_W:1];
                    r_on     <= {sum_on[0], r_on[PHASE_W-1:1]};
                    r_num    <= {sum_num[0], r_num[PHASE_W-1:1]};
                    if (r_cnt == 5'(PHASE_W - 1)) begin
                        r_cnt   <= '0;
                        r_rem   <= '0;
                        r_state <= PH_DIV;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                PH_DIV: begin
                    r_rem <= n_rem;
                    r_num <= {r_num[PHASE_W-2:0], q_bit};
                    if (r_cnt == 5'(PHASE_W - 1)) begin
                        r_cnt   <= '0;
                        r_done  <= 1'b1;
                        r_state <= PH_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                default: begin
                    r_state <= PH_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.on_bit   = r_on[0];
    assign o_rsp.quot_bit = r_num[0];

endmodule

### design/sdcst_checker.sv
module sdcst_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_stall,
    input logic i_out_valid,
    input logic i_out_stall,
    input logic i_fan_on,
    input logic i_drive_level
);

    // active-low pin always mirrors the load state
    a_drive_inverse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_drive_level != i_fan_on))
        else $error("drive level does not mirror fan state");

    // a waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_stall) |=> (i_out_valid && $stable(i_fan_on)))
        else $error("stalled result changed");

    // one word in flight: input is stalled right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !i_in_stall) |=> i_in_stall)
        else $error("second word taken while busy");

    // a new result only appears while the block is busy with a word
    a_result_from_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_stall))
        else $error("result without a word in flight");

endmodule

bind slow_duty_cycle_switch_timer sdcst_checker u_sdcst_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .i_in_stall    (o_in_stall),
    .i_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .i_fan_on      (o_fan_on),
    .i_drive_level (o_drive_level)
);
